// ----- sv/tnls_pkg.sv -----
package tnls_pkg;

  localparam logic OP_VERTEX   = 1'b0;
  localparam logic OP_TRIANGLE = 1'b1;

  localparam logic [7:0] AMBIENT_LEVEL = 8'd128;
  localparam logic [7:0] LEVEL_MAX     = 8'd255;
  localparam int unsigned DIRECT_SCALE = 127;

  localparam int COS_W = 17;
  localparam logic [COS_W-1:0] COS_ONE = 17'd65536;
  localparam int NRM_W = 24;
  localparam int Q3_W  = 52;
  localparam int R_W   = 84;
  localparam int ACC_W = 88;

  typedef struct packed {
    logic mode;
    logic amb;
  } tnls_side_t;

  function automatic logic edge_big(input logic signed [32:0] v);
    return (v[32] != v[31]) || ((v[32:31] == 2'b11) && (v[30:0] == 31'd0));
  endfunction

  function automatic logic signed [31:0] edge_halve(input logic signed [32:0] v,
                                                    input logic big);
    logic signed [32:0] t;
    logic signed [32:0] h;
    t = v + $signed({32'd0, v[32]});
    h = t >>> 1;
    return big ? h[31:0] : v[31:0];
  endfunction

endpackage

// ----- sv/tnls_req_if.sv -----
interface tnls_req_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic signed [31:0] z0;
  logic signed [31:0] x1;
  logic signed [31:0] y1;
  logic signed [31:0] z1;
  logic signed [31:0] x2;
  logic signed [31:0] y2;
  logic signed [31:0] z2;

  modport source(output valid, operation, x0, y0, z0, x1, y1, z1, x2, y2, z2,
                 input ready);
  modport sink(input valid, operation, x0, y0, z0, x1, y1, z1, x2, y2, z2,
               output ready);
endinterface

// ----- sv/tnls_res_if.sv -----
interface tnls_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] light_level;

  modport source(output valid, light_level, input ready);
  modport sink(input valid, light_level, output ready);
endinterface

// ----- sv/tnls_cos_root.sv -----
module tnls_cos_root (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  tnls_pkg::tnls_side_t            in_side,
  input  logic [tnls_pkg::Q3_W-1:0]       q3,
  input  logic [tnls_pkg::R_W-1:0]        r,
  output logic                            out_valid,
  output tnls_pkg::tnls_side_t            out_side,
  output logic [tnls_pkg::COS_W-1:0]      cos
);
  import tnls_pkg::*;

  // one result bit per stage, MSB first: keeps p = c^2*q3 and t = c*q3
  logic             vld  [COS_W];
  tnls_side_t       side [COS_W];
  logic [COS_W-1:0] cr   [COS_W];
  logic [ACC_W-1:0] pr   [COS_W];
  logic [ACC_W-1:0] tr   [COS_W];
  logic [Q3_W-1:0]  qr   [COS_W];
  logic [R_W-1:0]   rr   [COS_W];

  for (genvar j = 0; j < COS_W; j++) begin : g_bit
    localparam int K = COS_W - 1 - j;
    logic             vi;
    tnls_side_t       si;
    logic [COS_W-1:0] ci;
    logic [ACC_W-1:0] pi;
    logic [ACC_W-1:0] ti;
    logic [Q3_W-1:0]  qi;
    logic [R_W-1:0]   ri;
    logic [ACC_W-1:0] trial;
    logic             ok;

    if (j == 0) begin : g_first
      assign vi = in_valid;
      assign si = in_side;
      assign ci = '0;
      assign pi = '0;
      assign ti = '0;
      assign qi = q3;
      assign ri = r;
    end else begin : g_next
      assign vi = vld[j-1];
      assign si = side[j-1];
      assign ci = cr[j-1];
      assign pi = pr[j-1];
      assign ti = tr[j-1];
      assign qi = qr[j-1];
      assign ri = rr[j-1];
    end

    assign trial = pi + (ti << (K + 1)) + (ACC_W'(qi) << (2 * K));
    assign ok    = trial <= ACC_W'(ri);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[j] <= si;
        qr[j]   <= qi;
        rr[j]   <= ri;
        cr[j]   <= ok ? (ci | (COS_W'(1) << K)) : ci;
        pr[j]   <= ok ? trial : pi;
        tr[j]   <= ok ? (ti + (ACC_W'(qi) << K)) : ti;
      end
    end
  end

  assign out_valid = vld[COS_W-1];
  assign out_side  = side[COS_W-1];
  assign cos       = (cr[COS_W-1] > COS_ONE) ? COS_ONE : cr[COS_W-1];

endmodule

// ----- sv/terrain_normal_light_shader.sv -----
// Throughput: one item per cycle while res is not stalled; the cosine root resolves
// one bit per stage over 17 stages, behind 8 stages of edge, cross product and normal
// reduction. A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous, active high) clears all stage valid bits.
module terrain_normal_light_shader #(
  parameter int LIGHT_BANDS = 5
) (
  input  logic       clk,
  input  logic       rst,
  tnls_req_if.sink   req,
  tnls_res_if.source res
);
  import tnls_pkg::*;

  localparam int TOP    = (LIGHT_BANDS > 0) ? LIGHT_BANDS - 1 : 0;
  localparam int DIV    = (LIGHT_BANDS > 1) ? LIGHT_BANDS - 1 : 1;

  // quantized level for each direct term 0..127
  function automatic logic [1023:0] qtab_build();
    logic [1023:0] t;
    int b;
    t = '0;
    for (int d = 0; d < 128; d++) begin
      b = d * LIGHT_BANDS / 127;
      if (b > TOP) b = TOP;
      t[d*8 +: 8] = 8'(128 + b * 127 / DIV);
    end
    return t;
  endfunction

  localparam logic [1023:0] QTAB = qtab_build();

  logic en;
  assign en        = !res.valid || res.ready;
  assign req.ready = en;

  // stage 1: edges
  logic v1, mode1;
  logic signed [32:0] a0, a1, a2, b0, b1, b2;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= req.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mode1 <= req.operation;
      a0 <= {req.x1[31], req.x1} - {req.x0[31], req.x0};
      a1 <= {req.y1[31], req.y1} - {req.y0[31], req.y0};
      a2 <= {req.z1[31], req.z1} - {req.z0[31], req.z0};
      b0 <= {req.x2[31], req.x2} - {req.x0[31], req.x0};
      b1 <= {req.y2[31], req.y2} - {req.y0[31], req.y0};
      b2 <= {req.z2[31], req.z2} - {req.z0[31], req.z0};
    end
  end

  // stage 2: edge reduction and products
  logic abig, bbig;
  logic signed [31:0] ra0, ra1, ra2, rb0, rb1, rb2;
  assign abig = edge_big(a0) || edge_big(a1) || edge_big(a2);
  assign bbig = edge_big(b0) || edge_big(b1) || edge_big(b2);
  assign ra0  = edge_halve(a0, abig);
  assign ra1  = edge_halve(a1, abig);
  assign ra2  = edge_halve(a2, abig);
  assign rb0  = edge_halve(b0, bbig);
  assign rb1  = edge_halve(b1, bbig);
  assign rb2  = edge_halve(b2, bbig);

  logic v2, mode2;
  logic signed [63:0] m12, m21, m20, m02, m01, m10;
  logic signed [32:0] vn0, vn2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mode2 <= mode1;
      m12 <= ra1 * rb2;
      m21 <= ra2 * rb1;
      m20 <= ra2 * rb0;
      m02 <= ra0 * rb2;
      m01 <= ra0 * rb1;
      m10 <= ra1 * rb0;
      vn0 <= -a1;
      vn2 <= b1;
    end
  end

  // stage 3: normal
  logic v3;
  logic signed [63:0] n0, n1, n2;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  logic mode3;
  always_ff @(posedge clk) begin
    if (en) begin
      mode3 <= mode2;
      n0 <= (mode2 == OP_TRIANGLE) ? (m12 - m21) : 64'(vn0);
      n1 <= (mode2 == OP_TRIANGLE) ? (m20 - m02) : 64'sd65536;
      n2 <= (mode2 == OP_TRIANGLE) ? (m01 - m10) : 64'(vn2);
    end
  end

  // stage 4: magnitudes
  logic v4, mode4;
  logic [63:0] g0, g1, g2;
  logic [2:0]  sg4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mode4 <= mode3;
      g0  <= n0[63] ? 64'(-n0) : 64'(n0);
      g1  <= n1[63] ? 64'(-n1) : 64'(n1);
      g2  <= n2[63] ? 64'(-n2) : 64'(n2);
      sg4 <= {n2[63], n1[63], n0[63]};
    end
  end

  // stage 5: reduction shift
  logic [63:0] orv;
  logic [6:0]  blen;
  assign orv = g0 | g1 | g2;
  always_comb begin
    blen = '0;
    for (int i = 0; i < 64; i++) begin
      if (orv[i]) blen = 7'(i + 1);
    end
  end

  logic v5, mode5, zero5;
  logic [63:0] h0, h1, h2;
  logic [2:0]  sg5;
  logic [5:0]  sh5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mode5 <= mode4;
      zero5 <= (orv == 64'd0);
      h0 <= g0;
      h1 <= g1;
      h2 <= g2;
      sg5 <= sg4;
      sh5 <= (blen > 7'(NRM_W)) ? 6'(blen - 7'(NRM_W)) : 6'd0;
    end
  end

  // stage 6: reduced normal
  logic [63:0] e0, e1, e2;
  assign e0 = h0 >> sh5;
  assign e1 = h1 >> sh5;
  assign e2 = h2 >> sh5;

  logic v6, mode6, zero6;
  logic signed [NRM_W:0] rn0, rn1, rn2;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mode6 <= mode5;
      zero6 <= zero5;
      rn0 <= sg5[0] ? -$signed({1'b0, e0[NRM_W-1:0]}) : $signed({1'b0, e0[NRM_W-1:0]});
      rn1 <= sg5[1] ? -$signed({1'b0, e1[NRM_W-1:0]}) : $signed({1'b0, e1[NRM_W-1:0]});
      rn2 <= sg5[2] ? -$signed({1'b0, e2[NRM_W-1:0]}) : $signed({1'b0, e2[NRM_W-1:0]});
    end
  end

  // stage 7: sum and squares
  logic signed [NRM_W+2:0] ssum;
  assign ssum = 27'(rn0) + 27'(rn1) + 27'(rn2);

  logic v7;
  tnls_side_t side7;
  logic [NRM_W+1:0]   s7;
  logic [2*NRM_W-1:0] sq0, sq1, sq2;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side7.mode <= mode6;
      side7.amb  <= zero6 || ssum[NRM_W+2] || (ssum == '0);
      s7  <= ssum[NRM_W+1:0];
      sq0 <= (2*NRM_W)'(rn0 * rn0);
      sq1 <= (2*NRM_W)'(rn1 * rn1);
      sq2 <= (2*NRM_W)'(rn2 * rn2);
    end
  end

  // stage 8: 3Q and s^2 * 2^32
  logic [Q3_W-3:0] qsum;
  assign qsum = (Q3_W-2)'(sq0) + (Q3_W-2)'(sq1) + (Q3_W-2)'(sq2);

  logic v8;
  tnls_side_t side8;
  logic [Q3_W-1:0] q38;
  logic [Q3_W-1:0] ss8;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side8 <= side7;
      q38   <= Q3_W'(qsum) + {qsum, 1'b0};
      ss8   <= Q3_W'(s7) * Q3_W'(s7);
    end
  end

  // cosine root
  logic             cvalid;
  tnls_side_t       cside;
  logic [COS_W-1:0] cosv;

  tnls_cos_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .in_side   (side8),
    .q3        (q38),
    .r         ({ss8, 32'd0}),
    .out_valid (cvalid),
    .out_side  (cside),
    .cos       (cosv)
  );

  // level and bands
  logic [COS_W+6:0]  cprod;
  logic [8:0]        lraw;
  logic [7:0]        lv;
  logic [6:0]        dl;
  logic [7:0]        lq;
  logic [7:0]        lsel;

  always_comb begin
    cprod = (COS_W+7)'(cosv) * (COS_W+7)'(DIRECT_SCALE);
    lraw  = 9'(AMBIENT_LEVEL) + 9'(cprod[COS_W+6:16]);
    lv    = (lraw > 9'(LEVEL_MAX)) ? LEVEL_MAX : lraw[7:0];
    dl    = 7'(lv - AMBIENT_LEVEL);
    lq    = QTAB[{dl, 3'b000} +: 8];
    if (cside.amb) lsel = AMBIENT_LEVEL;
    else if (cside.mode == OP_TRIANGLE) lsel = lq;
    else lsel = lv;
  end

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (en) res.valid <= cvalid;
  end
  always_ff @(posedge clk) begin
    if (en) res.light_level <= lsel;
  end

  a_level_floor: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.light_level >= AMBIENT_LEVEL)
    else $error("light level below ambient");

  a_cos_cap: assert property (@(posedge clk) disable iff (rst)
    cvalid |-> cosv <= COS_ONE)
    else $error("cosine above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v4) && $stable(v8))
    else $error("pipeline moved during stall");

endmodule

// ----- dv/terrain_normal_light_shader_tb.sv -----
`timescale 1ns / 1ps

module terrain_normal_light_shader_tb;
  import tnls_pkg::*;

  localparam int BANDS = 5;
  localparam int N_RANDOM = 1750;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic operation;
    logic signed [31:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
  } shade_req_t;

  class light_scoreboard;
    logic [7:0] pending_levels[$];
    int mismatches;

    function automatic longint halve_trunc(longint v);
      return v / 2;
    endfunction

    function automatic longint absval(longint v);
      return v < 0 ? -v : v;
    endfunction

    function automatic logic [7:0] level_of_normal(longint nx, longint ny, longint nz);
      longint s;
      logic [127:0] q3, rhs, prod;
      longint unsigned lo, hi, mid;
      int unsigned lvl;
      if (nx == 0 && ny == 0 && nz == 0) return AMBIENT_LEVEL;
      while (absval(nx) >= 64'sd16777216 || absval(ny) >= 64'sd16777216 ||
             absval(nz) >= 64'sd16777216) begin
        nx = halve_trunc(nx); ny = halve_trunc(ny); nz = halve_trunc(nz);
      end
      s = nx + ny + nz;
      if (s <= 0) return AMBIENT_LEVEL;
      q3 = 128'(3) * (128'(nx * nx) + 128'(ny * ny) + 128'(nz * nz));
      rhs = (128'(s) * 128'(s)) << 32;
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        prod = 128'(mid * mid) * q3;
        if (prod <= rhs) lo = mid;
        else hi = mid - 1;
      end
      lvl = 128 + 32'((lo * 127) >> 16);
      if (lvl > 255) lvl = 255;
      return lvl[7:0];
    endfunction

    function automatic logic [7:0] shade(shade_req_t r);
      longint a[3], b[3], h0;
      int unsigned lvl, band, top, dv;
      if (r.operation == OP_VERTEX) begin
        h0 = longint'(r.y0);
        return level_of_normal(-(longint'(r.y1) - h0), 64'sd65536, longint'(r.y2) - h0);
      end
      a[0] = longint'(r.x1) - r.x0; a[1] = longint'(r.y1) - r.y0; a[2] = longint'(r.z1) - r.z0;
      b[0] = longint'(r.x2) - r.x0; b[1] = longint'(r.y2) - r.y0; b[2] = longint'(r.z2) - r.z0;
      while (absval(a[0]) >= 64'sd2147483648 || absval(a[1]) >= 64'sd2147483648 ||
             absval(a[2]) >= 64'sd2147483648)
        foreach (a[i]) a[i] = halve_trunc(a[i]);
      while (absval(b[0]) >= 64'sd2147483648 || absval(b[1]) >= 64'sd2147483648 ||
             absval(b[2]) >= 64'sd2147483648)
        foreach (b[i]) b[i] = halve_trunc(b[i]);
      lvl = 32'(level_of_normal(a[1] * b[2] - a[2] * b[1], a[2] * b[0] - a[0] * b[2],
                                a[0] * b[1] - a[1] * b[0]));
      top = BANDS > 0 ? BANDS - 1 : 0;
      dv = BANDS > 1 ? BANDS - 1 : 1;
      band = (lvl - 128) * BANDS / 127;
      if (band > top) band = top;
      lvl = 128 + band * 127 / dv;
      return lvl[7:0];
    endfunction

    function void note_request(shade_req_t r);
      pending_levels = {pending_levels, shade(r)};
    endfunction

    function void check_level(logic [7:0] got);
      logic [7:0] want;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected light_level %0d", got);
        return;
      end
      want = pending_levels.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("light_level mismatch: expected %0d got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int watchdog = 0;
  bit stim_done = 1'b0;
  light_scoreboard lights = new();

  tnls_req_if req();
  tnls_res_if res();

  terrain_normal_light_shader #(.LIGHT_BANDS(BANDS)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source)
  );

  always #4 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.operation = OP_VERTEX;
    {req.x0, req.y0, req.z0, req.x1, req.y1, req.z1, req.x2, req.y2, req.z2} = '0;
    res.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (req.valid && req.ready) begin
      lights.note_request('{req.operation, req.x0, req.y0, req.z0, req.x1, req.y1,
                            req.z1, req.x2, req.y2, req.z2});
    end
    if (res.valid && res.ready) lights.check_level(res.light_level);
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) watchdog <= 0;
    else watchdog <= watchdog + 1;
  end

  always @(posedge clk) begin
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("terrain_normal_light_shader_tb: errors");
      $finish;
    end
  end

  // result side: random stalls per item, sometimes long runs without stalls
  initial begin
    int waits;
    int calm;
    calm = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm > 0) begin
        waits = 0;
        calm--;
      end else begin
        waits = $urandom_range(0, 17);
        if ($urandom_range(0, 30) == 0) calm = $urandom_range(20, 80);
      end
      if (waits > 0) begin
        res.ready <= 1'b0;
        repeat (waits) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
      while (!(res.valid && res.ready)) @(posedge clk);
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8)) - 4;
      2: return 32'sh7fffffff - $urandom_range(0, 3);
      3: return 32'sh80000000 + $urandom_range(0, 3);
      4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic shade_req_t rand_request();
    shade_req_t r;
    r.operation = 1'($urandom_range(0, 1));
    r.x0 = rand_coord(); r.y0 = rand_coord(); r.z0 = rand_coord();
    r.x1 = rand_coord(); r.y1 = rand_coord(); r.z1 = rand_coord();
    r.x2 = rand_coord(); r.y2 = rand_coord(); r.z2 = rand_coord();
    if ($urandom_range(0, 3) != 0 && r.operation == OP_TRIANGLE) begin
      // small well-shaped triangle near a random origin
      r.x1 = r.x0 + ($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      r.y1 = r.y0 + ($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      r.z1 = r.z0 + ($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      r.x2 = r.x0 + ($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      r.y2 = r.y0 + ($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      r.z2 = r.z0 + ($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
    end
    return r;
  endfunction

  task automatic send_request(shade_req_t r);
    int waits;
    waits = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (waits > 0) begin
      req.valid <= 1'b0;
      repeat (waits) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= r.operation;
    req.x0 <= r.x0; req.y0 <= r.y0; req.z0 <= r.z0;
    req.x1 <= r.x1; req.y1 <= r.y1; req.z1 <= r.z1;
    req.x2 <= r.x2; req.y2 <= r.y2; req.z2 <= r.z2;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic shade_req_t tri_req(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz);
    return '{OP_TRIANGLE, ax, ay, az, bx, by, bz, cx, cy, cz};
  endfunction

  function automatic shade_req_t vtx_req(int h0, int h1, int h2);
    return '{OP_VERTEX, $urandom, h0, $urandom, $urandom, h1, $urandom, $urandom, h2, $urandom};
  endfunction

  initial begin
    shade_req_t directed[$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed = {directed, vtx_req(0, 0, 0)};
    directed = {directed, vtx_req(0, -65536, 65536)};
    directed = {directed, vtx_req(0, 32'sh7fffffff, 32'sh80000000)};
    directed = {directed, vtx_req(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff)};
    directed = {directed, vtx_req(32'sh7fffffff, 32'sh80000000, 32'sh80000000)};
    directed = {directed, vtx_req(0, 65536, -65536)};
    directed = {directed, vtx_req(-1, -1, -1)};
    directed = {directed, tri_req(0, 0, 0, 0, 0, 0, 0, 0, 0)};
    directed = {directed, tri_req(5, 5, 5, 5, 5, 5, 5, 5, 5)};
    directed = {directed, tri_req(0, 0, 0, 65536, 0, 0, 0, 0, 65536)};
    directed = {directed, tri_req(0, 0, 0, 0, 0, 65536, 65536, 0, 0)};
    directed = {directed, tri_req(0, 0, 0, 65536, 65536, 0, 0, 65536, 65536)};
    directed = {directed, tri_req(0, 0, 0, 65536, 0, -65536, -65536, 65536, 0)};
    directed = {directed, tri_req(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                  32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sh80000000, 32'sh7fffffff)};
    directed = {directed, tri_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                  32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                                  32'sh80000000, 32'sh80000000, 32'sh7fffffff)};
    directed = {directed, tri_req(32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 1,
                                  32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                                  32'sh7fffffff)};
    directed = {directed, tri_req(0, 0, 0, 2, 2, 2, 4, 4, 4)};
    directed = {directed, tri_req(0, 0, 0, 1, 0, 0, 0, 1, 0)};
    directed = {directed, tri_req(-1, -1, -1, -1, -1, -1, 32'sh7fffffff, 0, 0)};
    foreach (directed[i]) send_request(directed[i]);
    repeat (N_RANDOM) send_request(rand_request());
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int tail;
    wait (stim_done);
    while (lights.pending_levels.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 40) begin
      @(posedge clk);
      tail++;
    end
    if (lights.mismatches == 0 && lights.pending_levels.size() == 0) begin
      $display("terrain_normal_light_shader_tb: clean");
    end else begin
      $display("terrain_normal_light_shader_tb: errors");
    end
    $finish;
  end
endmodule
